// ===== sv/five_valued_gate_fault_eval_unit_assert.svh =====
// Assertion macros for the five-valued gate evaluation unit.
`ifndef FIVE_VALUED_GATE_FAULT_EVAL_UNIT_ASSERT_SVH
`define FIVE_VALUED_GATE_FAULT_EVAL_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FVGFE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FVGFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fvgfe_pkg.sv =====
// Types, codes and D-calculus functions for the five-valued gate evaluation unit.
package fvgfe_pkg;

    localparam int OP_W     = 4;
    localparam int FAULT_W  = 2;
    localparam int COUNT_W  = 4;
    localparam int VAL_W    = 3;
    localparam int SLOTS    = 8;
    localparam int HALF     = SLOTS / 2;
    localparam int PACKED_W = SLOTS * VAL_W;
    localparam int HI_W     = PACKED_W - HALF * VAL_W;

    // Largest fanin count that the evaluation honors.
    localparam int MAX_FANIN   = 8;
    localparam int FANIN_LIMIT = (MAX_FANIN < SLOTS) ? MAX_FANIN : SLOTS;

    typedef logic [VAL_W-1:0] val_t;

    localparam val_t V_ZERO = 3'd0;
    localparam val_t V_ONE  = 3'd1;
    localparam val_t V_X    = 3'd2;
    localparam val_t V_D    = 3'd3;
    localparam val_t V_DBAR = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_PI     = 4'd0,
        OP_PO     = 4'd1,
        OP_NOT    = 4'd2,
        OP_BUFF   = 4'd3,
        OP_FANOUT = 4'd4,
        OP_AND    = 4'd5,
        OP_OR     = 4'd6,
        OP_NAND   = 4'd7,
        OP_NOR    = 4'd8,
        OP_XOR    = 4'd9,
        OP_XNOR   = 4'd10
    } op_t;

    typedef enum logic [FAULT_W-1:0] {
        FK_NONE = 2'd0,
        FK_SA0  = 2'd1,
        FK_SA1  = 2'd2,
        FK_RSVD = 2'd3
    } fault_t;

    // Codes above D-bar carry no meaning and read as X.
    function automatic val_t v_norm(input val_t v);
        return (v > V_DBAR) ? V_X : v;
    endfunction

    function automatic logic good_of(input val_t v);
        return (v == V_ONE) || (v == V_D);
    endfunction

    function automatic logic bad_of(input val_t v);
        return (v == V_ONE) || (v == V_DBAR);
    endfunction

    function automatic val_t from_pair(input logic g, input logic f);
        val_t r;
        if (g && f)
            r = V_ONE;
        else if (!g && !f)
            r = V_ZERO;
        else if (g)
            r = V_D;
        else
            r = V_DBAR;
        return r;
    endfunction

    function automatic val_t v_not(input val_t a);
        return (a == V_X) ? V_X : from_pair(!good_of(a), !bad_of(a));
    endfunction

    function automatic val_t v_and(input val_t a, input val_t b);
        val_t r;
        if (a == V_ZERO || b == V_ZERO)
            r = V_ZERO;
        else if (a == V_X || b == V_X)
            r = V_X;
        else
            r = from_pair(good_of(a) & good_of(b), bad_of(a) & bad_of(b));
        return r;
    endfunction

    function automatic val_t v_or(input val_t a, input val_t b);
        val_t r;
        if (a == V_ONE || b == V_ONE)
            r = V_ONE;
        else if (a == V_X || b == V_X)
            r = V_X;
        else
            r = from_pair(good_of(a) | good_of(b), bad_of(a) | bad_of(b));
        return r;
    endfunction

    function automatic val_t v_xor(input val_t a, input val_t b);
        val_t r;
        if (a == V_X || b == V_X)
            r = V_X;
        else
            r = from_pair(good_of(a) ^ good_of(b), bad_of(a) ^ bad_of(b));
        return r;
    endfunction

    function automatic logic is_fold(input logic [OP_W-1:0] op);
        return (op >= OP_AND) && (op <= OP_XNOR);
    endfunction

    // One step of the fold of a multi-input gate.
    function automatic val_t fold_step(input logic [OP_W-1:0] op, input val_t acc,
                                       input val_t v);
        val_t r;
        case (op)
            OP_AND, OP_NAND: r = v_and(acc, v);
            OP_OR, OP_NOR:   r = v_or(acc, v);
            default:         r = v_xor(acc, v);
        endcase
        return r;
    endfunction

    function automatic val_t with_fault(input val_t v, input logic [FAULT_W-1:0] kind);
        val_t r;
        r = v;
        case (kind)
            FK_SA0:
            begin
                if (v == V_ONE)
                    r = V_D;
                else if (v == V_DBAR)
                    r = V_ZERO;
            end
            FK_SA1:
            begin
                if (v == V_ZERO)
                    r = V_DBAR;
                else if (v == V_D)
                    r = V_ONE;
            end
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/fvgfe_if.sv =====
// Valid/ready channel interfaces for gate words and result words.
interface fvgfe_in_if;
    logic                            valid;
    logic                            ready;
    logic [fvgfe_pkg::OP_W-1:0]      op;
    logic [fvgfe_pkg::FAULT_W-1:0]   fault_kind;
    logic [fvgfe_pkg::COUNT_W-1:0]   fanin_count;
    logic [fvgfe_pkg::PACKED_W-1:0]  fanin_values;

    modport source (output valid, output op, output fault_kind, output fanin_count,
                    output fanin_values, input ready);
    modport sink   (input valid, input op, input fault_kind, input fanin_count,
                    input fanin_values, output ready);
endinterface

interface fvgfe_out_if;
    logic                        valid;
    logic                        ready;
    logic [fvgfe_pkg::VAL_W-1:0] out_value;

    modport source (output valid, output out_value, input ready);
    modport sink   (input valid, input out_value, output ready);
endinterface

// ===== sv/five_valued_gate_fault_eval_unit.sv =====
// Five-valued (0, 1, X, D, D-bar) gate evaluation with stuck-at fault injection.
//
// The gate channel takes one word per gate: gate type, fault kind, fanin count
// and eight packed 3-bit fanin values. The result channel returns one word per
// gate word, in order, holding the 3-bit output value.
// The datapath is a three-stage pipeline. Stage one decodes the gate and folds
// fanin slots zero to three, stage two folds slots four to seven, and stage
// three applies the output inversion and the fault into the output register.
// An accepted word passes through the stage one, stage two and stage three
// registers before it is offered as a valid result. Throughput is one word
// per cycle while ready stays high; the three register stages set the latency.
// When the receiver holds ready low, each stage keeps its word until the one
// behind it frees up; gate ready drops only once all three stages are full, so
// no word is lost or repeated.
// Reset clears all stage valid bits; no result is presented until a new word
// has been accepted.
`include "five_valued_gate_fault_eval_unit_assert.svh"

module five_valued_gate_fault_eval_unit (
    input  logic         clk,
    input  logic         rst_n,
    fvgfe_in_if.sink     gate,
    fvgfe_out_if.source  result
);

    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic adv1, adv2, adv3;

    logic [fvgfe_pkg::OP_W-1:0]     s1_op_reg, s2_op_reg;
    logic [fvgfe_pkg::FAULT_W-1:0]  s1_kind_reg, s2_kind_reg;
    logic [fvgfe_pkg::COUNT_W-1:0]  s1_cnt_reg, cnt_sat;
    logic [fvgfe_pkg::HI_W-1:0]     s1_hi_reg;
    fvgfe_pkg::val_t                s1_acc_reg, s1_acc_next;
    fvgfe_pkg::val_t                s2_acc_reg, s2_acc_next;
    fvgfe_pkg::val_t                s3_val_reg, s3_val_next;
    fvgfe_pkg::val_t                slot0;

    assign adv3       = !s3_v_reg || result.ready;
    assign adv2       = !s2_v_reg || adv3;
    assign adv1       = !s1_v_reg || adv2;
    assign gate.ready = adv1;

    assign result.valid     = s3_v_reg;
    assign result.out_value = s3_val_reg;

    // Stage one: decode the gate type and fold the lower four slots.
    always_comb
    begin
        cnt_sat = (gate.fanin_count > fvgfe_pkg::COUNT_W'(fvgfe_pkg::FANIN_LIMIT))
                ? fvgfe_pkg::COUNT_W'(fvgfe_pkg::FANIN_LIMIT) : gate.fanin_count;
        slot0 = fvgfe_pkg::v_norm(gate.fanin_values[fvgfe_pkg::VAL_W-1:0]);
        case (gate.op)
            fvgfe_pkg::OP_PI:
                s1_acc_next = slot0;
            fvgfe_pkg::OP_PO, fvgfe_pkg::OP_BUFF, fvgfe_pkg::OP_FANOUT:
                s1_acc_next = (cnt_sat == '0) ? fvgfe_pkg::V_X : slot0;
            fvgfe_pkg::OP_NOT:
                s1_acc_next = (cnt_sat == '0) ? fvgfe_pkg::V_X : fvgfe_pkg::v_not(slot0);
            fvgfe_pkg::OP_AND, fvgfe_pkg::OP_OR, fvgfe_pkg::OP_NAND,
            fvgfe_pkg::OP_NOR, fvgfe_pkg::OP_XOR, fvgfe_pkg::OP_XNOR:
            begin
                s1_acc_next = (gate.op == fvgfe_pkg::OP_AND || gate.op == fvgfe_pkg::OP_NAND)
                            ? fvgfe_pkg::V_ONE : fvgfe_pkg::V_ZERO;
                for (int i = 0; i < fvgfe_pkg::HALF; i++)
                begin
                    if (fvgfe_pkg::COUNT_W'(i) < cnt_sat)
                        s1_acc_next = fvgfe_pkg::fold_step(gate.op, s1_acc_next,
                            fvgfe_pkg::v_norm(gate.fanin_values[i*fvgfe_pkg::VAL_W +:
                                                                fvgfe_pkg::VAL_W]));
                end
            end
            default:
                s1_acc_next = fvgfe_pkg::V_X;
        endcase
    end

    // Stage two: continue the fold over the upper four slots.
    always_comb
    begin
        s2_acc_next = s1_acc_reg;
        if (fvgfe_pkg::is_fold(s1_op_reg))
        begin
            for (int i = 0; i < fvgfe_pkg::HALF; i++)
            begin
                if (fvgfe_pkg::COUNT_W'(i + fvgfe_pkg::HALF) < s1_cnt_reg)
                    s2_acc_next = fvgfe_pkg::fold_step(s1_op_reg, s2_acc_next,
                        fvgfe_pkg::v_norm(s1_hi_reg[i*fvgfe_pkg::VAL_W +: fvgfe_pkg::VAL_W]));
            end
        end
    end

    // Stage three: output inversion, then the fault; primary outputs stay fault free.
    always_comb
    begin
        s3_val_next = s2_acc_reg;
        if (s2_op_reg inside {fvgfe_pkg::OP_NAND, fvgfe_pkg::OP_NOR, fvgfe_pkg::OP_XNOR})
            s3_val_next = fvgfe_pkg::v_not(s3_val_next);
        if (s2_op_reg != fvgfe_pkg::OP_PO)
            s3_val_next = fvgfe_pkg::with_fault(s3_val_next, s2_kind_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_v_reg <= gate.valid;
            if (adv2)
                s2_v_reg <= s1_v_reg;
            if (adv3)
                s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_op_reg   <= gate.op;
            s1_kind_reg <= gate.fault_kind;
            s1_cnt_reg  <= cnt_sat;
            s1_hi_reg   <= gate.fanin_values[fvgfe_pkg::PACKED_W-1:fvgfe_pkg::HALF*fvgfe_pkg::VAL_W];
            s1_acc_reg  <= s1_acc_next;
        end
        if (adv2)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_kind_reg <= s1_kind_reg;
            s2_acc_reg  <= s2_acc_next;
        end
        if (adv3)
            s3_val_reg <= s3_val_next;
    end

    `FVGFE_ASSERT_NEXT(a_accept_fills_stage1, gate.valid && gate.ready, s1_v_reg,
        "accepted word did not reach stage one")
    `FVGFE_ASSERT_IMPL(a_full_stall_blocks_input,
        s1_v_reg && s2_v_reg && s3_v_reg && !result.ready, !gate.ready,
        "gate word taken while the pipeline is full and stalled")
    `FVGFE_ASSERT_IMPL(a_result_code_legal, result.valid, result.out_value <= fvgfe_pkg::V_DBAR,
        "result value outside the five-valued code set")

endmodule

// ===== bench/tb_five_valued_gate_fault_eval_unit.sv =====
// Self-checking bench for the five-valued gate evaluation unit with random handshake timing.
module tb_five_valued_gate_fault_eval_unit;

    localparam int OP_W        = fvgfe_pkg::OP_W;
    localparam int FAULT_W     = fvgfe_pkg::FAULT_W;
    localparam int COUNT_W     = fvgfe_pkg::COUNT_W;
    localparam int VAL_W       = fvgfe_pkg::VAL_W;
    localparam int PACKED_W    = fvgfe_pkg::PACKED_W;
    localparam int SLOTS       = fvgfe_pkg::SLOTS;
    localparam int FANIN_LIMIT = fvgfe_pkg::FANIN_LIMIT;

    localparam logic [OP_W-1:0]    OP_CODE_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam int                 MAX_WAIT     = 8;
    localparam int                 RANDOM_GATES = 1700;
    localparam int                 HOLD_CYCLES  = 300;
    localparam int                 HOLD_AFTER   = 500;
    localparam int                 SETTLE       = 12;
    localparam int                 CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [FAULT_W-1:0]  fault_kind;
        logic [COUNT_W-1:0]  fanin_count;
        logic [PACKED_W-1:0] fanin_values;
    } gate_word_t;

    typedef struct {
        gate_word_t word;
        int         gap;
        bit         drain;
    } gate_job_t;

    // A value as a (good machine, faulty machine) bit pair; known is low for X.
    typedef struct packed {
        logic known;
        logic good;
        logic bad;
    } pair_t;

    logic clk;
    logic rst_n;

    fvgfe_in_if  gate_ch ();
    fvgfe_out_if result_ch ();

    five_valued_gate_fault_eval_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .gate   (gate_ch),
        .result (result_ch)
    );

    gate_job_t        gate_jobs[$];
    fvgfe_pkg::val_t  expected_values[$];
    gate_job_t        next_job;
    bit               next_staged;
    int               gap_left;
    int               stall_left;
    bit               rx_calm;
    bit               tx_calm;
    bit               rx_hold;
    int               errors;
    int               accepted_words;
    int               cycle_count;

    function automatic pair_t code_to_pair(input fvgfe_pkg::val_t c);
        pair_t p;
        case (c)
            fvgfe_pkg::V_ZERO:  p = '{known: 1'b1, good: 1'b0, bad: 1'b0};
            fvgfe_pkg::V_ONE:   p = '{known: 1'b1, good: 1'b1, bad: 1'b1};
            fvgfe_pkg::V_D:     p = '{known: 1'b1, good: 1'b1, bad: 1'b0};
            fvgfe_pkg::V_DBAR:  p = '{known: 1'b1, good: 1'b0, bad: 1'b1};
            default:            p = '{known: 1'b0, good: 1'b0, bad: 1'b0};
        endcase
        return p;
    endfunction

    function automatic fvgfe_pkg::val_t pair_to_code(input pair_t p);
        fvgfe_pkg::val_t c;
        if (!p.known)
            c = fvgfe_pkg::V_X;
        else
        begin
            case ({p.good, p.bad})
                2'b00:   c = fvgfe_pkg::V_ZERO;
                2'b11:   c = fvgfe_pkg::V_ONE;
                2'b10:   c = fvgfe_pkg::V_D;
                default: c = fvgfe_pkg::V_DBAR;
            endcase
        end
        return c;
    endfunction

    function automatic bit pair_is(input pair_t p, input logic level);
        return p.known && (p.good == level) && (p.bad == level);
    endfunction

    // A controlling value wins over X; otherwise X spreads.
    function automatic pair_t pair_and(input pair_t a, input pair_t b);
        pair_t r;
        if (pair_is(a, 1'b0) || pair_is(b, 1'b0))
            r = '{known: 1'b1, good: 1'b0, bad: 1'b0};
        else if (!a.known || !b.known)
            r = '0;
        else
            r = '{known: 1'b1, good: a.good & b.good, bad: a.bad & b.bad};
        return r;
    endfunction

    function automatic pair_t pair_or(input pair_t a, input pair_t b);
        pair_t r;
        if (pair_is(a, 1'b1) || pair_is(b, 1'b1))
            r = '{known: 1'b1, good: 1'b1, bad: 1'b1};
        else if (!a.known || !b.known)
            r = '0;
        else
            r = '{known: 1'b1, good: a.good | b.good, bad: a.bad | b.bad};
        return r;
    endfunction

    function automatic pair_t pair_xor(input pair_t a, input pair_t b);
        pair_t r;
        if (!a.known || !b.known)
            r = '0;
        else
            r = '{known: 1'b1, good: a.good ^ b.good, bad: a.bad ^ b.bad};
        return r;
    endfunction

    function automatic pair_t pair_invert(input pair_t a);
        pair_t r;
        r = a;
        if (a.known)
        begin
            r.good = !a.good;
            r.bad  = !a.bad;
        end
        return r;
    endfunction

    // A stuck-at fault pins the faulty machine bit of any known value.
    function automatic pair_t pair_stuck(input pair_t a, input logic [FAULT_W-1:0] kind);
        pair_t r;
        r = a;
        if (a.known && kind == fvgfe_pkg::FK_SA0)
            r.bad = 1'b0;
        else if (a.known && kind == fvgfe_pkg::FK_SA1)
            r.bad = 1'b1;
        return r;
    endfunction

    function automatic fvgfe_pkg::val_t gate_output(input gate_word_t w);
        pair_t           acc;
        pair_t           slot0;
        int              fanins;
        fvgfe_pkg::val_t res;
        fanins = (w.fanin_count > FANIN_LIMIT) ? FANIN_LIMIT : int'(w.fanin_count);
        slot0  = code_to_pair(w.fanin_values[VAL_W-1:0]);
        acc    = '0;
        res    = fvgfe_pkg::V_X;
        case (w.op)
            fvgfe_pkg::OP_PI:
                res = pair_to_code(pair_stuck(slot0, w.fault_kind));
            fvgfe_pkg::OP_PO:
                res = (fanins == 0) ? fvgfe_pkg::V_X : pair_to_code(slot0);
            fvgfe_pkg::OP_NOT, fvgfe_pkg::OP_BUFF, fvgfe_pkg::OP_FANOUT:
            begin
                if (fanins != 0)
                    acc = (w.op == fvgfe_pkg::OP_NOT) ? pair_invert(slot0) : slot0;
                res = pair_to_code(pair_stuck(acc, w.fault_kind));
            end
            fvgfe_pkg::OP_AND, fvgfe_pkg::OP_NAND, fvgfe_pkg::OP_OR, fvgfe_pkg::OP_NOR,
            fvgfe_pkg::OP_XOR, fvgfe_pkg::OP_XNOR:
            begin
                acc = code_to_pair((w.op == fvgfe_pkg::OP_AND || w.op == fvgfe_pkg::OP_NAND)
                                   ? fvgfe_pkg::V_ONE : fvgfe_pkg::V_ZERO);
                for (int i = 0; i < fanins; i++)
                begin
                    case (w.op)
                        fvgfe_pkg::OP_AND, fvgfe_pkg::OP_NAND:
                            acc = pair_and(acc, code_to_pair(w.fanin_values[VAL_W*i +: VAL_W]));
                        fvgfe_pkg::OP_OR, fvgfe_pkg::OP_NOR:
                            acc = pair_or(acc, code_to_pair(w.fanin_values[VAL_W*i +: VAL_W]));
                        default:
                            acc = pair_xor(acc, code_to_pair(w.fanin_values[VAL_W*i +: VAL_W]));
                    endcase
                end
                if (w.op == fvgfe_pkg::OP_NAND || w.op == fvgfe_pkg::OP_NOR
                    || w.op == fvgfe_pkg::OP_XNOR)
                    acc = pair_invert(acc);
                res = pair_to_code(pair_stuck(acc, w.fault_kind));
            end
            default:
                res = fvgfe_pkg::V_X;
        endcase
        return res;
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic queue_gate(input logic [OP_W-1:0] op, input logic [FAULT_W-1:0] kind,
                              input logic [COUNT_W-1:0] count,
                              input logic [PACKED_W-1:0] values, input bit drain);
        gate_job_t job;
        job.word  = '{op: op, fault_kind: kind, fanin_count: count, fanin_values: values};
        job.gap   = draw_wait(tx_calm);
        job.drain = drain;
        gate_jobs.push_back(job);
    endtask

    // Mostly well-formed codes with few X, so that D and D-bar reach the output.
    function automatic logic [PACKED_W-1:0] random_fanins(input bit noisy);
        logic [PACKED_W-1:0] values;
        fvgfe_pkg::val_t     code;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (noisy)
                code = fvgfe_pkg::val_t'($urandom_range(0, 7));
            else if ($urandom_range(0, 11) == 0)
                code = fvgfe_pkg::V_X;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       code = fvgfe_pkg::V_ZERO;
                    1:       code = fvgfe_pkg::V_ONE;
                    2:       code = fvgfe_pkg::V_D;
                    default: code = fvgfe_pkg::V_DBAR;
                endcase
            end
            values[VAL_W*i +: VAL_W] = code;
        end
        return values;
    endfunction

    task automatic queue_random_gate(input bit drain);
        logic [OP_W-1:0]    op;
        logic [FAULT_W-1:0] kind;
        logic [COUNT_W-1:0] count;
        if ($urandom_range(0, 11) == 0)
            op = OP_W'($urandom_range(int'(fvgfe_pkg::OP_XNOR) + 1, int'(OP_CODE_MAX)));
        else if ($urandom_range(0, 1) == 0)
            op = OP_W'($urandom_range(int'(fvgfe_pkg::OP_AND), int'(fvgfe_pkg::OP_XNOR)));
        else
            op = OP_W'($urandom_range(int'(fvgfe_pkg::OP_PI), int'(fvgfe_pkg::OP_XNOR)));
        if ($urandom_range(0, 11) == 0)
            kind = fvgfe_pkg::FK_RSVD;
        else
            kind = FAULT_W'($urandom_range(int'(fvgfe_pkg::FK_NONE), int'(fvgfe_pkg::FK_SA1)));
        if ($urandom_range(0, 11) == 0)
            count = COUNT_W'($urandom_range(FANIN_LIMIT + 1, int'(COUNT_MAX)));
        else if ($urandom_range(0, 7) == 0)
            count = '0;
        else
            count = COUNT_W'($urandom_range(1, FANIN_LIMIT));
        queue_gate(op, kind, count, random_fanins($urandom_range(0, 9) == 0), drain);
    endtask

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        forever #4 clk = !clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Gate word driver: each queued job waits out its gap, and a draining job
    // also waits until every result in flight has come back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_ch.valid        <= 1'b0;
            gate_ch.op           <= '0;
            gate_ch.fault_kind   <= '0;
            gate_ch.fanin_count  <= '0;
            gate_ch.fanin_values <= '0;
            next_staged = 1'b0;
            gap_left    = 0;
        end
        else
        begin
            if (gate_ch.valid && gate_ch.ready)
            begin
                expected_values.push_back(gate_output('{op: gate_ch.op,
                    fault_kind: gate_ch.fault_kind, fanin_count: gate_ch.fanin_count,
                    fanin_values: gate_ch.fanin_values}));
                accepted_words++;
            end
            if (!(gate_ch.valid && !gate_ch.ready))
            begin
                if (!next_staged && gate_jobs.size() != 0)
                begin
                    next_job    = gate_jobs.pop_front();
                    next_staged = 1'b1;
                    gap_left    = next_job.gap;
                end
                if (next_staged && gap_left == 0
                    && !(next_job.drain && expected_values.size() != 0))
                begin
                    gate_ch.op           <= next_job.word.op;
                    gate_ch.fault_kind   <= next_job.word.fault_kind;
                    gate_ch.fanin_count  <= next_job.word.fanin_count;
                    gate_ch.fanin_values <= next_job.word.fanin_values;
                    gate_ch.valid        <= 1'b1;
                    next_staged = 1'b0;
                end
                else
                begin
                    gate_ch.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Result monitor: checks each word against the oldest prediction and
    // draws a random stall, which may be none, after each one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("out_value: expected none, got %0d", result_ch.out_value);
                    errors++;
                end
                else if (result_ch.out_value !== expected_values[0])
                begin
                    $error("out_value: expected %0d, got %0d", expected_values[0],
                           result_ch.out_value);
                    errors++;
                    void'(expected_values.pop_front());
                end
                else
                    void'(expected_values.pop_front());
                stall_left = draw_wait(rx_calm);
            end
            else if (stall_left > 0)
                stall_left--;
            result_ch.ready <= !rx_hold && stall_left == 0;
        end
    end

    // One long receiver stall while the sender keeps offering words.
    initial
    begin
        while (accepted_words < HOLD_AFTER)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        queue_gate(fvgfe_pkg::OP_PI, fvgfe_pkg::FK_SA0, 4'd1,
                   {{7{fvgfe_pkg::V_X}}, fvgfe_pkg::V_ONE}, 1'b0);
        queue_gate(fvgfe_pkg::OP_PI, fvgfe_pkg::FK_SA0, 4'd0,
                   {{7{fvgfe_pkg::V_ONE}}, fvgfe_pkg::V_DBAR}, 1'b0);
        queue_gate(fvgfe_pkg::OP_PI, fvgfe_pkg::FK_SA1, 4'd3,
                   {{7{fvgfe_pkg::V_D}}, fvgfe_pkg::V_ZERO}, 1'b0);
        queue_gate(fvgfe_pkg::OP_PI, fvgfe_pkg::FK_NONE, 4'd1,
                   {{7{fvgfe_pkg::V_ZERO}}, 3'd7}, 1'b0);
        queue_gate(fvgfe_pkg::OP_PO, fvgfe_pkg::FK_SA1, 4'd0,
                   {{7{fvgfe_pkg::V_ONE}}, fvgfe_pkg::V_ZERO}, 1'b0);
        queue_gate(fvgfe_pkg::OP_PO, fvgfe_pkg::FK_SA0, 4'd1,
                   {{7{fvgfe_pkg::V_ZERO}}, fvgfe_pkg::V_ONE}, 1'b0);
        queue_gate(fvgfe_pkg::OP_NOT, fvgfe_pkg::FK_SA1, 4'd0,
                   {{7{fvgfe_pkg::V_ONE}}, fvgfe_pkg::V_ONE}, 1'b0);
        queue_gate(fvgfe_pkg::OP_NOT, fvgfe_pkg::FK_NONE, 4'd1,
                   {{7{fvgfe_pkg::V_ZERO}}, fvgfe_pkg::V_D}, 1'b0);
        queue_gate(fvgfe_pkg::OP_BUFF, fvgfe_pkg::FK_SA1, 4'd1,
                   {{7{fvgfe_pkg::V_ZERO}}, fvgfe_pkg::V_D}, 1'b0);
        queue_gate(fvgfe_pkg::OP_FANOUT, fvgfe_pkg::FK_SA0, 4'd0,
                   {{7{fvgfe_pkg::V_ONE}}, fvgfe_pkg::V_ONE}, 1'b0);
        queue_gate(fvgfe_pkg::OP_AND, fvgfe_pkg::FK_RSVD, 4'd0,
                   {8{fvgfe_pkg::V_ZERO}}, 1'b0);
        queue_gate(fvgfe_pkg::OP_AND, fvgfe_pkg::FK_NONE, 4'd2,
                   {{6{fvgfe_pkg::V_ONE}}, fvgfe_pkg::V_ZERO, fvgfe_pkg::V_X}, 1'b0);
        queue_gate(fvgfe_pkg::OP_AND, fvgfe_pkg::FK_SA0, 4'd8,
                   {fvgfe_pkg::V_D, fvgfe_pkg::V_ONE, fvgfe_pkg::V_D, fvgfe_pkg::V_ONE,
                    fvgfe_pkg::V_D, fvgfe_pkg::V_D, fvgfe_pkg::V_ONE, fvgfe_pkg::V_D}, 1'b0);
        queue_gate(fvgfe_pkg::OP_OR, fvgfe_pkg::FK_SA1, 4'd0,
                   {8{fvgfe_pkg::V_ONE}}, 1'b0);
        queue_gate(fvgfe_pkg::OP_OR, fvgfe_pkg::FK_NONE, 4'd2,
                   {{6{fvgfe_pkg::V_ZERO}}, fvgfe_pkg::V_ONE, fvgfe_pkg::V_X}, 1'b0);
        queue_gate(fvgfe_pkg::OP_NAND, fvgfe_pkg::FK_SA1, 4'd8,
                   {{7{fvgfe_pkg::V_ONE}}, fvgfe_pkg::V_D}, 1'b0);
        queue_gate(fvgfe_pkg::OP_NOR, fvgfe_pkg::FK_SA0, COUNT_MAX,
                   {8{fvgfe_pkg::V_ZERO}}, 1'b0);
        queue_gate(fvgfe_pkg::OP_XOR, fvgfe_pkg::FK_NONE, 4'd8,
                   {fvgfe_pkg::V_D, fvgfe_pkg::V_DBAR, fvgfe_pkg::V_ONE, fvgfe_pkg::V_D,
                    fvgfe_pkg::V_ZERO, fvgfe_pkg::V_DBAR, fvgfe_pkg::V_D, fvgfe_pkg::V_ONE},
                   1'b0);
        queue_gate(fvgfe_pkg::OP_XNOR, fvgfe_pkg::FK_SA0, 4'd0,
                   {8{fvgfe_pkg::V_D}}, 1'b0);
        queue_gate(fvgfe_pkg::OP_XNOR, fvgfe_pkg::FK_NONE, 4'd3,
                   {{5{fvgfe_pkg::V_ONE}}, fvgfe_pkg::V_ONE, 3'd5, fvgfe_pkg::V_D}, 1'b0);
        queue_gate(OP_CODE_MAX, fvgfe_pkg::FK_SA1, 4'd8,
                   {8{fvgfe_pkg::V_ZERO}}, 1'b0);
        queue_gate(OP_W'(int'(fvgfe_pkg::OP_XNOR) + 1), fvgfe_pkg::FK_NONE, 4'd8,
                   {8{fvgfe_pkg::V_ONE}}, 1'b0);
        queue_gate(fvgfe_pkg::OP_OR, fvgfe_pkg::FK_RSVD, COUNT_MAX, '1, 1'b0);
        queue_gate(fvgfe_pkg::OP_AND, fvgfe_pkg::FK_SA1, 4'd9,
                   {8{fvgfe_pkg::V_DBAR}}, 1'b0);

        for (int n = 0; n < RANDOM_GATES; n++)
            queue_random_gate(n == 0 || n % 400 == 399);

        while (gate_jobs.size() != 0 || next_staged || gate_ch.valid
               || expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0 && expected_values.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
